>>> hdl/nbmf_pkg.sv
// Package: frame geometry, widths, codes and item types of the bright-mean fill block.
package nbmf_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int DIM_MAX      = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
    localparam int DEPTH        = FRAME_WIDTH * FRAME_HEIGHT;

    localparam int XW       = $clog2(FRAME_WIDTH);
    localparam int YW       = $clog2(FRAME_HEIGHT);
    localparam int RAD_W    = $clog2(DIM_MAX);
    localparam int COORD_W  = RAD_W + 2;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int QUO_W    = 8;
    localparam int SUM_W    = CNT_W + QUO_W;
    localparam int STEP_W   = $clog2(QUO_W);

    localparam logic [7:0] THRESHOLD_RESET = 8'h60;

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic       req_type;
        logic [9:0] pos_x;
        logic [8:0] pos_y;
        logic [7:0] pixel_in;
    } req_t;

    typedef struct packed {
        logic [7:0] filled_value;
        logic [9:0] radius_used;
        logic       none_bright;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

>>> hdl/nbmf_frame_mem.sv
// Frame store: one write port, one registered read port.
module nbmf_frame_mem (
    input  logic              clk,
    input  nbmf_pkg::mem_req_t mem_req,
    output logic [7:0]        rd_data
);
    import nbmf_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rd_data_reg <= mem[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/nbmf_div.sv
// Restoring divider: one quotient bit per cycle, quotient known to fit QUO_W bits.
module nbmf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nbmf_pkg::SUM_W-1:0]  dividend,
    input  logic [nbmf_pkg::CNT_W-1:0]  divisor,
    output logic                        done,
    output logic [nbmf_pkg::QUO_W-1:0]  quotient
);
    import nbmf_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  trial;
    logic              fits;

    always_comb
    begin
        trial = SUM_W'(den_reg) << step_reg;
        fits  = (rem_reg >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg && fits)
        begin
            rem_reg           <= rem_reg - trial;
            quo_reg[step_reg] <= 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/nearest_bright_mean_fill.sv
// Top level: frame store with ring-growing bright-pixel mean search.
//
//  channel | signals                        | direction | payload
//  req     | req_valid, req_ready, req      | in        | req_t (type, x, y, pixel)
//  rsp     | rsp_valid, rsp_ready, rsp      | out       | rsp_t (value, radius, flag)
//  cfg     | cfg_valid, cfg_ready, cfg_data | in        | bright threshold, 8 bits
//
// A query walks each ring through the single read port of the frame store, one pixel per
// cycle (out-of-frame positions included); once a ring holds a bright pixel, the serial divider runs.
// An in-frame query that finds nothing bright walks until the window covers the whole frame.
// One item is in work at a time; a store is taken while a result waits in the output register.
// Reset clears control and sets the threshold to 0x60; the frame store is not cleared.
module nearest_bright_mean_fill (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  nbmf_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output nbmf_pkg::rsp_t   rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);
    import nbmf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_CHECK = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        thr_reg;
    coord_t            cx_reg, cy_reg, px_reg, py_reg;
    logic [RAD_W-1:0]  s_reg, limit_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              rd_vld_reg, rd_cen_reg;
    logic [7:0]        cen_val_reg;
    rsp_t              res_reg, rsp_reg;
    logic              rsp_valid_reg;

    mem_req_t          mem_req;
    logic [7:0]        rd_data;
    logic              div_start, div_done;
    logic [QUO_W-1:0]  quotient;

    logic              req_acc, is_query, in_frame;
    coord_t            qx, qy, lim_a, lim_b, lim_c;
    coord_t            s_c, lo_x, hi_x, lo_y, hi_y;
    coord_t            px_next, py_next;
    logic              ring_end, inb, out_free;

    nbmf_frame_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    nbmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign req_acc   = req_valid && req_ready;
    assign is_query  = (req.req_type == REQ_QUERY);
    assign in_frame  = (int'(req.pos_x) < FRAME_WIDTH) && (int'(req.pos_y) < FRAME_HEIGHT);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign div_start = (state_reg == S_CHECK) && (cnt_reg != '0);

    // search limit: radius at which the clipped window covers the frame
    always_comb
    begin
        qx    = COORD_W'(req.pos_x);
        qy    = COORD_W'(req.pos_y);
        lim_a = (qx > coord_t'(FRAME_WIDTH - 1) - qx) ? qx : coord_t'(FRAME_WIDTH - 1) - qx;
        lim_b = (qy > coord_t'(FRAME_HEIGHT - 1) - qy) ? qy : coord_t'(FRAME_HEIGHT - 1) - qy;
        lim_c = (lim_a > lim_b) ? lim_a : lim_b;
        if (lim_c < coord_t'(1))
        begin
            lim_c = coord_t'(1);
        end
    end

    // ring walk: center first, then each ring's top row, both sides row by row, then bottom row
    always_comb
    begin
        s_c      = $signed({2'b00, s_reg});
        lo_x     = cx_reg - s_c;
        hi_x     = cx_reg + s_c;
        lo_y     = cy_reg - s_c;
        hi_y     = cy_reg + s_c;
        px_next  = px_reg;
        py_next  = py_reg;
        ring_end = 1'b0;
        if (s_reg == '0)
        begin
            px_next = cx_reg - coord_t'(1);
            py_next = cy_reg - coord_t'(1);
        end
        else if ((py_reg == lo_y) || (py_reg == hi_y))
        begin
            if (px_reg != hi_x)
            begin
                px_next = px_reg + coord_t'(1);
            end
            else if (py_reg == hi_y)
            begin
                ring_end = 1'b1;
            end
            else
            begin
                py_next = py_reg + coord_t'(1);
                px_next = lo_x;
            end
        end
        else
        begin
            if (px_reg == lo_x)
            begin
                px_next = hi_x;
            end
            else
            begin
                py_next = py_reg + coord_t'(1);
                px_next = lo_x;
            end
        end
        inb = (px_reg >= coord_t'(0)) && (px_reg < coord_t'(FRAME_WIDTH))
              && (py_reg >= coord_t'(0)) && (py_reg < coord_t'(FRAME_HEIGHT));
    end

    always_comb
    begin
        mem_req.we    = req_acc && !is_query && in_frame;
        mem_req.waddr = ADDR_W'(req.pos_y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(req.pos_x);
        mem_req.wdata = req.pixel_in;
        mem_req.re    = (state_reg == S_WALK) && inb;
        mem_req.raddr = ADDR_W'(py_reg[YW-1:0]) * ADDR_W'(FRAME_WIDTH)
                        + ADDR_W'(px_reg[XW-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc && is_query)
                begin
                    state_next = in_frame ? S_WALK : S_FIN;
                end
            end
            S_WALK:
            begin
                if (ring_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (cnt_reg != '0)
                begin
                    state_next = S_DIV;
                end
                else if (s_reg == limit_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= THRESHOLD_RESET;
            rd_vld_reg    <= 1'b0;
            rd_cen_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= mem_req.re;
            rd_cen_reg <= (state_reg == S_WALK) && (s_reg == '0);
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc && is_query)
        begin
            cx_reg    <= qx;
            cy_reg    <= qy;
            px_reg    <= qx;
            py_reg    <= qy;
            s_reg     <= '0;
            limit_reg <= RAD_W'(lim_c);
            sum_reg   <= '0;
            cnt_reg   <= '0;
            res_reg   <= '{filled_value: '0, radius_used: '0, none_bright: 1'b1};
        end
        else
        begin
            if (state_reg == S_WALK)
            begin
                px_reg <= px_next;
                py_reg <= py_next;
                if (s_reg == '0)
                begin
                    s_reg <= RAD_W'(1);
                end
            end
            if ((state_reg == S_CHECK) && (cnt_reg == '0) && (s_reg != limit_reg))
            begin
                s_reg  <= s_reg + 1'b1;
                px_reg <= lo_x - coord_t'(1);
                py_reg <= lo_y - coord_t'(1);
            end
            if ((state_reg == S_CHECK) && (cnt_reg == '0) && (s_reg == limit_reg))
            begin
                res_reg <= '{filled_value: cen_val_reg, radius_used: '0, none_bright: 1'b1};
            end
            if ((state_reg == S_DIV) && div_done)
            begin
                res_reg <= '{filled_value: quotient, radius_used: 10'(s_reg),
                             none_bright: 1'b0};
            end
            if (rd_vld_reg && (rd_data > thr_reg))
            begin
                sum_reg <= sum_reg + SUM_W'(rd_data);
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (rd_cen_reg)
        begin
            cen_val_reg <= rd_data;
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hdl/nbmf_checker.sv
// Port checker for the bright-mean fill block and its bind.
module nbmf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input nbmf_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input nbmf_pkg::rsp_t rsp
);
    import nbmf_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    a_flag_radius: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.none_bright && (rsp.radius_used != '0)))
        else $error("nothing-bright result with nonzero radius");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.req_type == REQ_QUERY) |=> !req_ready)
        else $error("ready after query item");

    a_store_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.req_type == REQ_STORE) |=> req_ready)
        else $error("store item did not finish in one cycle");

endmodule

bind nearest_bright_mean_fill nbmf_checker u_nbmf_checker (.*);

>>> tb/tb_nearest_bright_mean_fill.sv
// Testbench for nearest_bright_mean_fill: corner patches, edge queries, random dark-patch probes.
module tb_nearest_bright_mean_fill;
    timeunit 1ns;
    timeprecision 1ps;

    import nbmf_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2_000_000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int X_TOP           = (1 << XW) - 1;
    localparam int Y_TOP           = (1 << YW) - 1;

    class fill_tracker;
        bit [7:0]   frame_copy [DEPTH];
        bit         written [DEPTH];
        bit         touched_unwritten;
        logic [7:0] threshold;
        rsp_t       expected_fills [$];
        int         mismatches;

        function new();
            threshold         = THRESHOLD_RESET;
            touched_unwritten = 1'b0;
            mismatches        = 0;
        endfunction

        task report_mismatch(string what);
            if (mismatches < 60)
                $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        // value of a bright pixel, 0 when outside the frame or not bright
        function int lit_value(int px, int py);
            bit [7:0] v;
            int       idx;
            if (px < 0 || px >= FRAME_WIDTH || py < 0 || py >= FRAME_HEIGHT)
                return 0;
            idx = py * FRAME_WIDTH + px;
            if (!written[idx])
                touched_unwritten = 1'b1;
            v = frame_copy[idx];
            return (v > threshold) ? int'(v) : 0;
        endfunction

        function rsp_t mean_search(req_t item);
            rsp_t   res;
            int     x, y, lim, s, dx, dy, v, cnt;
            longint sum;
            res = '0;
            touched_unwritten = 1'b0;
            x   = item.pos_x;
            y   = item.pos_y;
            if (x >= FRAME_WIDTH || y >= FRAME_HEIGHT)
            begin
                res.none_bright = 1'b1;
                return res;
            end
            lim = x;
            if (FRAME_WIDTH - 1 - x > lim) lim = FRAME_WIDTH - 1 - x;
            if (y > lim) lim = y;
            if (FRAME_HEIGHT - 1 - y > lim) lim = FRAME_HEIGHT - 1 - y;
            if (lim < 1) lim = 1;
            sum = lit_value(x, y);
            cnt = (sum != 0) ? 1 : 0;
            for (s = 1; s <= lim; s++)
            begin
                for (dy = -s; dy <= s; dy++)
                begin
                    // top and bottom rows whole, side columns only at the ends
                    for (dx = -s; dx <= s; dx += (dy == -s || dy == s) ? 1 : 2 * s)
                    begin
                        v = lit_value(x + dx, y + dy);
                        if (v != 0)
                        begin
                            sum += v;
                            cnt++;
                        end
                    end
                end
                // search reached a pixel with no value yet
                if (touched_unwritten)
                    return res;
                if (cnt != 0)
                begin
                    res.filled_value = 8'(sum / cnt);
                    res.radius_used  = 10'(s);
                    return res;
                end
            end
            res.filled_value = frame_copy[y * FRAME_WIDTH + x];
            res.none_bright  = 1'b1;
            return res;
        endfunction

        function void note_request(req_t item);
            int idx;
            if (item.req_type == REQ_STORE)
            begin
                if (item.pos_x < FRAME_WIDTH && item.pos_y < FRAME_HEIGHT)
                begin
                    idx = int'(item.pos_y) * FRAME_WIDTH + int'(item.pos_x);
                    frame_copy[idx] = item.pixel_in;
                    written[idx]    = 1'b1;
                end
            end
            else
                expected_fills.insert(expected_fills.size(), mean_search(item));
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (expected_fills.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: value %0d radius %0d flag %0d",
                                          got.filled_value, got.radius_used, got.none_bright));
                return;
            end
            want = expected_fills.pop_front();
            if (got.filled_value !== want.filled_value)
                report_mismatch($sformatf("filled_value %0d, expected %0d",
                                          got.filled_value, want.filled_value));
            if (got.radius_used !== want.radius_used)
                report_mismatch($sformatf("radius_used %0d, expected %0d",
                                          got.radius_used, want.radius_used));
            if (got.none_bright !== want.none_bright)
                report_mismatch($sformatf("none_bright %0d, expected %0d",
                                          got.none_bright, want.none_bright));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    fill_tracker tracker = new();
    bit          calm = 1'b0;
    int          accepted_reqs = 0;
    int          quiet_cycles = 0;

    nearest_bright_mean_fill i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5ns clk = ~clk;

    function automatic req_t make_item(logic kind, int x, int y, int value);
        req_t item;
        item.req_type = kind;
        item.pos_x    = 10'(x);
        item.pos_y    = 9'(y);
        item.pixel_in = 8'(value);
        return item;
    endfunction

    // coordinates biased toward the frame edges
    function automatic int pick_coord(int span);
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 2);
            1: return $urandom_range(span - 3, span - 1);
            default: return $urandom_range(0, span - 1);
        endcase
    endfunction

    function automatic int dim_pixel(int thr);
        case ($urandom_range(0, 7))
            0, 1: return thr;
            2: return 0;
            default: return $urandom_range(0, thr);
        endcase
    endfunction

    function automatic int lit_pixel(int thr);
        case ($urandom_range(0, 7))
            0, 1: return thr + 1;
            2: return 255;
            default: return $urandom_range(thr + 1, 255);
        endcase
    endfunction

    task automatic send_item(input req_t item, input bit may_pause);
        if (may_pause && !calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        tracker.note_request(item);
        accepted_reqs++;
    endtask

    // queries go out only when their search reads written pixels alone
    task automatic send_query(int x, int y, int value);
        req_t item;
        item = make_item(REQ_QUERY, x, y, value);
        void'(tracker.mean_search(item));
        if (!tracker.touched_unwritten)
            send_item(item, 1'b1);
    endtask

    task automatic store_pixel(int x, int y, int value);
        if (x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT)
            send_item(make_item(REQ_STORE, x, y, value), 1'b1);
    endtask

    // every in-frame pixel within radius 2 gets a value
    task automatic fill_block(int cx, int cy);
        int dx, dy;
        for (dy = -2; dy <= 2; dy++)
            for (dx = -2; dx <= 2; dx++)
                store_pixel(cx + dx, cy + dy, $urandom_range(0, 255));
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (tracker.expected_fills.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.threshold = value;
    endtask

    // dark square of radius r, a few bright pixels on ring r, center query, maybe a second one
    task automatic probe_dark_patch();
        int thr, r, cx, cy, dx, dy, pos;
        thr = tracker.threshold;
        r   = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        cx  = pick_coord(FRAME_WIDTH);
        cy  = pick_coord(FRAME_HEIGHT);
        for (dy = -r; dy <= r; dy++)
            for (dx = -r; dx <= r; dx++)
                store_pixel(cx + dx, cy + dy, dim_pixel(thr));
        repeat ($urandom_range(1, 3))
        begin
            pos = $urandom_range(0, 2 * r) - r;
            case ($urandom_range(0, 3))
                0: store_pixel(cx + pos, cy - r, lit_pixel(thr));
                1: store_pixel(cx + pos, cy + r, lit_pixel(thr));
                2: store_pixel(cx - r, cy + pos, lit_pixel(thr));
                default: store_pixel(cx + r, cy + pos, lit_pixel(thr));
            endcase
        end
        send_query(cx, cy, $urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0)
        begin
            dx = cx + $urandom_range(0, 2 * r) - r;
            dy = cy + $urandom_range(0, 2 * r) - r;
            if (dx >= 0 && dx < FRAME_WIDTH && dy >= 0 && dy < FRAME_HEIGHT)
                send_query(dx, dy, $urandom_range(0, 255));
        end
    endtask

    task automatic send_stray();
        int x, y;
        x = $urandom_range(0, FRAME_WIDTH - 1);
        y = $urandom_range(0, FRAME_HEIGHT - 1);
        case ($urandom_range(0, 5))
            0: x = $urandom_range(FRAME_WIDTH, X_TOP);
            1: y = $urandom_range(FRAME_HEIGHT, Y_TOP);
            2:
            begin
                x = $urandom_range(0, X_TOP);
                y = $urandom_range(0, Y_TOP);
            end
            default: ;
        endcase
        if ($urandom_range(0, 1) == 0)
            send_item(make_item(REQ_STORE, x, y, $urandom_range(0, 255)), 1'b1);
        else
            send_query(x, y, $urandom_range(0, 255));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_nearest_bright_mean_fill: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : result_side
        int stall;
        stall = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                tracker.check_result(rsp);
            if (stall > 0)
            begin
                stall--;
                rsp_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 5) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int phase, target, thr;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // written neighborhoods around the corners and the center
        fill_block(0, 0);
        fill_block(FRAME_WIDTH - 1, FRAME_HEIGHT - 1);
        fill_block(FRAME_WIDTH - 1, 0);
        fill_block(0, FRAME_HEIGHT - 1);
        fill_block(FRAME_WIDTH / 2, FRAME_HEIGHT / 2);

        // corners, threshold boundary, out-of-frame stores and queries
        send_item(make_item(REQ_STORE, 0, 0, 8'h00), 1'b1);
        send_item(make_item(REQ_STORE, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 8'hFF), 1'b1);
        send_item(make_item(REQ_STORE, FRAME_WIDTH - 1, 0, THRESHOLD_RESET), 1'b1);
        send_item(make_item(REQ_STORE, 0, FRAME_HEIGHT - 1, THRESHOLD_RESET + 1), 1'b1);
        send_item(make_item(REQ_STORE, X_TOP, Y_TOP, 8'hAA), 1'b1);
        send_item(make_item(REQ_STORE, FRAME_WIDTH, 0, 8'h55), 1'b1);
        send_item(make_item(REQ_STORE, 0, FRAME_HEIGHT, 8'h55), 1'b1);
        send_query(0, 0, 8'hFF);
        send_query(FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 8'h00);
        send_query(FRAME_WIDTH - 1, 0, 8'hFF);
        send_query(0, FRAME_HEIGHT - 1, 8'h00);
        send_query(X_TOP, Y_TOP, 8'hFF);
        send_query(FRAME_WIDTH, 0, 8'h00);
        send_query(0, FRAME_HEIGHT, 8'h00);
        send_query(X_TOP, 0, 8'h00);
        send_query(FRAME_WIDTH / 2, FRAME_HEIGHT / 2, 8'h00);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0: thr = 0;
                1: thr = 254;
                default: thr = $urandom_range(0, 254);
            endcase
            write_threshold(8'(thr));
            calm   = (phase == PHASES - 1);
            target = accepted_reqs + ITEMS_PER_PHASE;
            while (accepted_reqs < target)
            begin
                if ($urandom_range(0, 9) < 6)
                    probe_dark_patch();
                else
                    send_stray();
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("tb_nearest_bright_mean_fill: clean");
        else
            $display("tb_nearest_bright_mean_fill: errors");
        $finish;
    end

endmodule

>>> filelist.f
hdl/nbmf_pkg.sv
hdl/nbmf_frame_mem.sv
hdl/nbmf_div.sv
hdl/nearest_bright_mean_fill.sv
hdl/nbmf_checker.sv
tb/tb_nearest_bright_mean_fill.sv
